// ===== rtl/hts_pkg.sv =====
package hts_pkg;

	// default window length
	localparam int WINDOW_LEN_DEF = 5;

	// field widths
	localparam int SAMPLE_W = 32;
	localparam int TIME_W   = 32;
	localparam int AVG_W    = 26;
	localparam int CMD_W    = 32;
	localparam int KIND_W   = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int JUMP_W     = 31;
	localparam int BAND_W     = 8;
	localparam int DELAY_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_BAND       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RUNNING_DELAY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_DELAY      = 3'd5;

	// register reset values
	localparam logic [JUMP_W-1:0]  JUMP_LIMIT_RST      = 31'd1000000;
	localparam logic [BAND_W-1:0]  SLOW_BAND_RST       = 8'd5;
	localparam logic [BAND_W-1:0]  DEVIATION_LIMIT_RST = 8'd5;
	localparam logic [BAND_W-1:0]  STOP_BAND_RST       = 8'd5;
	localparam logic [DELAY_W-1:0] RUNNING_DELAY_RST   = 16'd100;
	localparam logic [DELAY_W-1:0] IDLE_DELAY_RST      = 16'd500;

	// output scaling by 1/100: (x * SCALE_RECIP) >> SCALE_SHIFT, exact for x below 2^32
	localparam logic [31:0] SCALE_RECIP = 32'h51eb851f;
	localparam int          SCALE_SHIFT = 37;

	// command codes
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JUMP,
		ST_SUB,
		ST_ADD,
		ST_LOAD1,
		ST_DIV1,
		ST_SCALE,
		ST_SIGN,
		ST_DETECT,
		ST_FIRE,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/hand_turn_speed_follower.sv =====
// Speed follower for a hand-turned motor.
// Input channel (in_valid/in_ready) takes one word: speed_sample and now_ms.
// Output channel (out_valid/out_ready) gives one word per input word:
// average_scaled, command_kind, command_speed and motor_running.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
// the user must write it only while the block is idle, which the block
// does not enforce; unknown indexes are ignored. The average comes from
// a restoring divider, one quotient bit a cycle, that divides the window
// sum by the fill count; the scaling by 1/100 is one registered
// reciprocal multiply. A dropped sample skips the window update states
// ST_SUB and ST_ADD.
// in_ready is high only while the sequencer is idle, so no new word is
// taken until the last one has been pushed to the output register; a finished
// word sits in the output register, so the next input word is taken while it waits.
// If the receiver stalls, the next result is held until the output register
// empties, and no further input is taken meanwhile.
// Reset empties the window, stops the motor state, clears any deviation
// timing and loads the configuration defaults.
module hand_turn_speed_follower #(
	parameter int WINDOW_LEN = hts_pkg::WINDOW_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [hts_pkg::SAMPLE_W-1:0] speed_sample,
	input  logic [hts_pkg::TIME_W-1:0]          now_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [hts_pkg::AVG_W-1:0]    average_scaled,
	output logic [hts_pkg::KIND_W-1:0]          command_kind,
	output logic signed [hts_pkg::CMD_W-1:0]    command_speed,
	output logic                               motor_running,
	input  logic                               cfg_write,
	input  logic [hts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import hts_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int DVS_W  = (CNT_W > 1) ? CNT_W : 2;
	localparam int IT_W   = $clog2(SUM_W + 1);
	localparam int MAG_W  = AVG_W - 1;
	localparam int PROD_W = 2 * SAMPLE_W;

	// configuration registers
	logic [JUMP_W-1:0]  jump_limit_q;
	logic [BAND_W-1:0]  slow_band_q;
	logic [BAND_W-1:0]  deviation_limit_q;
	logic [BAND_W-1:0]  stop_band_q;
	logic [DELAY_W-1:0] running_delay_q;
	logic [DELAY_W-1:0] idle_delay_q;

	// sequencer and item state
	state_t state_q, state_d;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]          now_q;
	logic signed [SAMPLE_W-1:0] win_q [WINDOW_LEN];
	logic [CNT_W-1:0]           count_q;
	logic [SLOT_W-1:0]          slot_q;
	logic signed [SAMPLE_W-1:0] last_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       run_q;
	logic signed [AVG_W-1:0]    cmdsc_q;
	logic                       dv_q;
	logic [TIME_W-1:0]          ds_q;

	// divider and result
	logic [DVS_W-1:0]        rem_q;
	logic [SUM_W-1:0]        quo_q;
	logic [DVS_W-1:0]        dvs_q;
	logic [IT_W-1:0]         it_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic signed [AVG_W-1:0] cur_q;
	logic [KIND_W-1:0]       kind_q;
	logic signed [CMD_W-1:0] cmd_q;

	// output register
	logic                    out_valid_q;
	logic signed [AVG_W-1:0] avg_out_q;
	logic [KIND_W-1:0]       kind_out_q;
	logic signed [CMD_W-1:0] cmd_out_q;
	logic                    run_out_q;

	logic push;
	logic in_ready_c;

	// jump test on the latched sample
	logic signed [SAMPLE_W:0] jdiff;
	logic [SAMPLE_W:0]        jabs;
	logic                     keep;

	assign jdiff = {sample_q[SAMPLE_W-1], sample_q} - {last_q[SAMPLE_W-1], last_q};
	assign jabs  = jdiff[SAMPLE_W] ? -jdiff : jdiff;
	assign keep  = (count_q == '0) || (jabs < {2'b00, jump_limit_q});

	// divider step: one quotient bit
	logic [DVS_W+1:0] trial;
	logic             ge;

	assign trial = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, dvs_q};
	assign ge    = ~trial[DVS_W+1];

	// sum magnitude for the division
	logic [SUM_W-1:0] sum_mag;
	assign sum_mag = sum_q[SUM_W-1] ? -sum_q : sum_q;

	// deviation test while running
	logic [AVG_W-1:0]        cmd_mag;
	logic signed [AVG_W:0]   ddiff;
	logic [AVG_W:0]          dabs;
	logic                    dev;

	assign cmd_mag = cmdsc_q[AVG_W-1] ? -cmdsc_q : cmdsc_q;
	assign ddiff   = {cur_q[AVG_W-1], cur_q} - {cmdsc_q[AVG_W-1], cmdsc_q};
	assign dabs    = ddiff[AVG_W] ? -ddiff : ddiff;
	assign dev     = ((cmd_mag <= {{(AVG_W-BAND_W){1'b0}}, slow_band_q}) && (dabs != '0)) ||
		((cmd_mag > {{(AVG_W-BAND_W){1'b0}}, slow_band_q}) &&
		 (dabs >= {{(AVG_W+1-BAND_W){1'b0}}, deviation_limit_q}));

	// re-command decision
	logic [TIME_W-1:0]       elapsed;
	logic [DELAY_W-1:0]      limit;
	logic                    fire;
	logic [AVG_W-1:0]        cur_mag;
	logic signed [CMD_W-1:0] cur_ext;
	logic signed [CMD_W-1:0] cur_x100;

	assign elapsed  = now_q - ds_q;
	assign limit    = run_q ? running_delay_q : idle_delay_q;
	assign fire     = dv_q && (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, limit});
	assign cur_mag  = cur_q[AVG_W-1] ? -cur_q : cur_q;
	assign cur_ext  = {{(CMD_W-AVG_W){cur_q[AVG_W-1]}}, cur_q};
	assign cur_x100 = (cur_ext <<< 6) + (cur_ext <<< 5) + (cur_ext <<< 2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_JUMP;
			end
			ST_JUMP: begin
				state_d = keep ? ST_SUB : ST_LOAD1;
			end
			ST_SUB:   state_d = ST_ADD;
			ST_ADD:   state_d = ST_LOAD1;
			ST_LOAD1: state_d = ST_DIV1;
			ST_DIV1: begin
				if (it_q == IT_W'(1)) state_d = ST_SCALE;
			end
			ST_SCALE:  state_d = ST_SIGN;
			ST_SIGN:   state_d = ST_DETECT;
			ST_DETECT: state_d = ST_FIRE;
			ST_FIRE:   state_d = ST_OUT;
			ST_OUT: begin
				if (push) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs of the sequencer
	always_comb begin
		in_ready_c = 1'b0;
		push       = 1'b0;
		case (state_q)
			ST_IDLE: in_ready_c = 1'b1;
			ST_OUT:  push = ~out_valid_q | out_ready;
			default: begin
				in_ready_c = 1'b0;
				push       = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q      <= JUMP_LIMIT_RST;
			slow_band_q       <= SLOW_BAND_RST;
			deviation_limit_q <= DEVIATION_LIMIT_RST;
			stop_band_q       <= STOP_BAND_RST;
			running_delay_q   <= RUNNING_DELAY_RST;
			idle_delay_q      <= IDLE_DELAY_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_JUMP_LIMIT:      jump_limit_q      <= cfg_data[JUMP_W-1:0];
				REG_SLOW_BAND:       slow_band_q       <= cfg_data[BAND_W-1:0];
				REG_DEVIATION_LIMIT: deviation_limit_q <= cfg_data[BAND_W-1:0];
				REG_STOP_BAND:       stop_band_q       <= cfg_data[BAND_W-1:0];
				REG_RUNNING_DELAY:   running_delay_q   <= cfg_data[DELAY_W-1:0];
				REG_IDLE_DELAY:      idle_delay_q      <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// window storage
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) win_q[slot_q] <= sample_q;
	end

	// input latch, divider and scaling datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sample_q <= speed_sample;
					now_q    <= now_ms;
				end
			end
			ST_LOAD1: begin
				rem_q <= '0;
				quo_q <= sum_mag;
				dvs_q <= DVS_W'(count_q);
				neg_q <= sum_q[SUM_W-1];
				it_q  <= IT_W'(SUM_W);
			end
			ST_DIV1: begin
				rem_q <= ge ? trial[DVS_W-1:0] : {rem_q[DVS_W-2:0], quo_q[SUM_W-1]};
				quo_q <= {quo_q[SUM_W-2:0], ge};
				it_q  <= it_q - IT_W'(1);
			end
			ST_SCALE: begin
				prod_q <= PROD_W'(quo_q[SAMPLE_W-1:0]) * PROD_W'(SCALE_RECIP);
			end
			ST_SIGN: begin
				cur_q <= neg_q ? -$signed({1'b0, prod_q[SCALE_SHIFT +: MAG_W]})
				               :  $signed({1'b0, prod_q[SCALE_SHIFT +: MAG_W]});
			end
			default: ;
		endcase
	end

	// window bookkeeping, motor state and deviation timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			slot_q  <= '0;
			last_q  <= '0;
			sum_q   <= '0;
			run_q   <= 1'b0;
			cmdsc_q <= '0;
			dv_q    <= 1'b0;
			ds_q    <= '0;
			kind_q  <= KIND_NONE;
			cmd_q   <= '0;
		end else begin
			case (state_q)
				ST_SUB: begin
					if (count_q == CNT_W'(WINDOW_LEN))
						sum_q <= sum_q - {{(SUM_W-SAMPLE_W){win_q[slot_q][SAMPLE_W-1]}},
							win_q[slot_q]};
					else
						count_q <= count_q + CNT_W'(1);
				end
				ST_ADD: begin
					sum_q  <= sum_q + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
					slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
					last_q <= sample_q;
				end
				ST_DETECT: begin
					if (run_q) begin
						if (dev) begin
							if (!dv_q) begin
								dv_q <= 1'b1;
								ds_q <= now_q;
							end
						end else begin
							dv_q <= 1'b0;
						end
					end else if (cur_q != '0 && !dv_q) begin
						dv_q <= 1'b1;
						ds_q <= now_q;
					end else if (cur_q == '0 && dv_q) begin
						dv_q <= 1'b0;
					end
				end
				ST_FIRE: begin
					kind_q <= KIND_NONE;
					cmd_q  <= '0;
					if (fire) begin
						dv_q <= 1'b0;
						if (cur_mag < {{(AVG_W-BAND_W){1'b0}}, stop_band_q}) begin
							run_q  <= 1'b0;
							kind_q <= KIND_STOP;
						end else begin
							run_q   <= 1'b1;
							cmdsc_q <= cur_q;
							kind_q  <= KIND_START;
							cmd_q   <= cur_x100;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (push) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			avg_out_q  <= cur_q;
			kind_out_q <= kind_q;
			cmd_out_q  <= cmd_q;
			run_out_q  <= run_q;
		end
	end

	assign in_ready       = in_ready_c;
	assign out_valid      = out_valid_q;
	assign average_scaled = avg_out_q;
	assign command_kind   = kind_out_q;
	assign command_speed  = cmd_out_q;
	assign motor_running  = run_out_q;

endmodule
